@@ hw/rtl/flsa_pkg.sv @@
// ----------------------------------------------------------------------------
// flsa_pkg
// Shared types and constants for the free list slot allocator.
// ----------------------------------------------------------------------------
package flsa_pkg;

	localparam int SLOT_W  = 10;
	localparam int COUNT_W = 11;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef struct packed {
		logic init_wr;
		logic accept;
		logic exec;
		logic load_calc;
		logic load_pend;
		logic load_from_pend;
	} flsa_cmd_t;

	typedef struct packed {
		logic init_last;
	} flsa_sts_t;

endpackage

@@ hw/rtl/flsa_req_if.sv @@
// ----------------------------------------------------------------------------
// flsa_req_if
// Request channel: allocate or free command word.
// ----------------------------------------------------------------------------
interface flsa_req_if import flsa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              cmd;
	logic [SLOT_W-1:0] freed_slot;

	modport source (output valid, output cmd, output freed_slot, input ready);
	modport sink   (input valid, input cmd, input freed_slot, output ready);
endinterface

@@ hw/rtl/flsa_rsp_if.sv @@
// ----------------------------------------------------------------------------
// flsa_rsp_if
// Response channel: slot handed out, grant flag and occupancy.
// ----------------------------------------------------------------------------
interface flsa_rsp_if import flsa_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [SLOT_W-1:0]  given_slot;
	logic               granted;
	logic [COUNT_W-1:0] occupied_count;

	modport source (output valid, output given_slot, output granted,
		output occupied_count, input ready);
	modport sink   (input valid, input given_slot, input granted,
		input occupied_count, output ready);
endinterface

@@ hw/rtl/flsa_ram.sv @@
// ----------------------------------------------------------------------------
// flsa_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module flsa_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/flsa_ctrl.sv @@
// ----------------------------------------------------------------------------
// flsa_ctrl
// Sequencer: link table initialisation pass, then accept / execute / hand over.
// ----------------------------------------------------------------------------
module flsa_ctrl import flsa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	input  flsa_sts_t sts,
	output flsa_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_WAIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;
	logic   accept;

	assign out_free  = !out_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = out_valid_q;

	always_comb begin
		cmd                = '0;
		cmd.accept         = accept;
		cmd.init_wr        = (state_q == ST_INIT);
		cmd.exec           = (state_q == ST_EXEC);
		cmd.load_calc      = (state_q == ST_EXEC) && out_free;
		cmd.load_pend      = (state_q == ST_EXEC) && !out_free;
		cmd.load_from_pend = (state_q == ST_WAIT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_calc || cmd.load_from_pend) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: begin
					if (sts.init_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ hw/rtl/flsa_dp.sv @@
// ----------------------------------------------------------------------------
// flsa_dp
// Head register, link table, occupancy count and response registers.
// ----------------------------------------------------------------------------
module flsa_dp import flsa_pkg::*; #(
	parameter int SLOTS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  flsa_cmd_t          cmd,
	output flsa_sts_t          sts,
	input  logic               req_cmd,
	input  logic [SLOT_W-1:0]  req_freed_slot,
	output logic [SLOT_W-1:0]  given_slot,
	output logic               granted,
	output logic [COUNT_W-1:0] occupied_count
);

	localparam int SW   = $clog2(SLOTS);
	localparam int LW   = $clog2(SLOTS + 1);
	localparam int CMPW = (LW > SLOT_W) ? LW : SLOT_W;
	localparam logic [LW-1:0] NULL_LINK = LW'(SLOTS);

	logic [LW-1:0]      head_q;
	logic [LW-1:0]      in_use_q;
	logic [SW-1:0]      idx_q;
	logic               op_cmd_q;
	logic [SLOT_W-1:0]  op_slot_q;

	logic [SLOT_W-1:0]  pend_given_q;
	logic               pend_granted_q;
	logic [COUNT_W-1:0] pend_count_q;
	logic [SLOT_W-1:0]  out_given_q;
	logic               out_granted_q;
	logic [COUNT_W-1:0] out_count_q;

	logic               mem_we;
	logic [SW-1:0]      mem_waddr;
	logic [LW-1:0]      mem_wdata;
	logic [SW-1:0]      mem_raddr;
	logic [LW-1:0]      mem_rdata;

	logic               alloc_ok;
	logic               free_ok;
	logic [LW-1:0]      next_head;
	logic [LW-1:0]      next_use;
	logic [SLOT_W-1:0]  calc_given;
	logic [COUNT_W-1:0] calc_count;

	assign alloc_ok = (op_cmd_q == CMD_ALLOC) && (head_q < NULL_LINK);
	assign free_ok  = (op_cmd_q == CMD_FREE) && (CMPW'(op_slot_q) < CMPW'(SLOTS));

	always_comb begin
		next_head = head_q;
		next_use  = in_use_q;
		if (alloc_ok) begin
			next_head = (mem_rdata > NULL_LINK) ? NULL_LINK : mem_rdata;
			if (in_use_q < NULL_LINK) begin
				next_use = in_use_q + LW'(1);
			end
		end else if (free_ok) begin
			next_head = LW'(op_slot_q);
			if (in_use_q != '0) begin
				next_use = in_use_q - LW'(1);
			end
		end
	end

	assign calc_given = alloc_ok ? SLOT_W'(head_q) : '0;
	assign calc_count = COUNT_W'(next_use);

	// head is read on every cycle; the word taken at accept is used in exec
	assign mem_raddr = (head_q < NULL_LINK) ? SW'(head_q) : '0;
	assign mem_we    = cmd.init_wr || (cmd.exec && free_ok);
	assign mem_waddr = cmd.init_wr ? idx_q : SW'(op_slot_q);
	assign mem_wdata = cmd.init_wr ? (LW'(idx_q) + LW'(1)) : head_q;

	assign sts.init_last = (idx_q == SW'(SLOTS - 1));

	flsa_ram #(
		.WIDTH (LW),
		.DEPTH (SLOTS)
	) u_link_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			in_use_q <= '0;
			idx_q    <= '0;
		end else begin
			if (cmd.init_wr) begin
				idx_q <= idx_q + SW'(1);
			end
			if (cmd.exec) begin
				head_q   <= next_head;
				in_use_q <= next_use;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_cmd_q  <= req_cmd;
			op_slot_q <= req_freed_slot;
		end
		if (cmd.load_pend) begin
			pend_given_q   <= calc_given;
			pend_granted_q <= alloc_ok || free_ok;
			pend_count_q   <= calc_count;
		end
		if (cmd.load_calc) begin
			out_given_q   <= calc_given;
			out_granted_q <= alloc_ok || free_ok;
			out_count_q   <= calc_count;
		end else if (cmd.load_from_pend) begin
			out_given_q   <= pend_given_q;
			out_granted_q <= pend_granted_q;
			out_count_q   <= pend_count_q;
		end
	end

	assign given_slot     = out_given_q;
	assign granted        = out_granted_q;
	assign occupied_count = out_count_q;

endmodule

@@ hw/rtl/free_list_slot_allocator_top.sv @@
// ----------------------------------------------------------------------------
// free_list_slot_allocator_top
// LIFO free list of slots: allocate pops the head, free pushes a slot.
//
//   port  dir   word
//   req   sink  cmd, freed_slot
//   rsp   src   given_slot, granted, occupied_count
//
// Each word is accepted, then the head's link comes out of the
// registered link RAM (or the freed slot's link is written).
// After reset the link RAM is filled, one link per slot; req.ready is low then.
// A response held by rsp.ready stays in the output register; the next word may
// be accepted meanwhile, its response parks in a spare register and req.ready
// stays low until the output frees up.
// ----------------------------------------------------------------------------
module free_list_slot_allocator_top import flsa_pkg::*; #(
	parameter int SLOTS = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	flsa_req_if.sink   req,
	flsa_rsp_if.source rsp
);

	flsa_cmd_t cmd;
	flsa_sts_t sts;

	flsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	flsa_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.req_cmd        (req.cmd),
		.req_freed_slot (req.freed_slot),
		.given_slot     (rsp.given_slot),
		.granted        (rsp.granted),
		.occupied_count (rsp.occupied_count)
	);

endmodule

@@ hw/rtl/flsa_checker.sv @@
// ----------------------------------------------------------------------------
// flsa_checker
// Port level checks for the free list slot allocator.
// ----------------------------------------------------------------------------
module flsa_checker import flsa_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic [SLOT_W-1:0]  given_slot,
	input logic               granted,
	input logic [COUNT_W-1:0] occupied_count
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=>
			$stable(given_slot) && $stable(granted) && $stable(occupied_count))
		else $error("response word changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second word taken while one is in flight");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !granted |-> given_slot == '0)
		else $error("refused response carries a slot");

endmodule

bind free_list_slot_allocator_top flsa_checker u_flsa_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.given_slot     (rsp.given_slot),
	.granted        (rsp.granted),
	.occupied_count (rsp.occupied_count)
);
